// ===== hdl/slot_ring_claim_manager_defines.svh =====
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SLOT_RING_CLAIM_MANAGER_DEFINES_SVH
`define SLOT_RING_CLAIM_MANAGER_DEFINES_SVH

// Same-cycle implication.
`define SRCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define SRCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== hdl/srcm_pkg.sv =====
package srcm_pkg;

  // Default ring depth handed to the top level
  localparam int MAX_SLOTS_DEFAULT = 256;

  // Fixed field widths
  localparam int POS_W       = 32;
  localparam int SLOT_W      = 8;
  localparam int OFFSET_W    = 24;
  localparam int OCC_W       = 9;
  localparam int CAP_W       = 4;
  localparam int STRIDE_W    = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_LOG2 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_STRIDE   = 2'd1;

  // Register reset values
  localparam logic [CAP_W-1:0]    CAP_LOG2_RESET = 4'd8;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 17'd64;

  // Per-slot state word ahead of the payload
  localparam logic [OFFSET_W-1:0] STATE_WORD_BYTES = 24'd4;

  // Busy map encoding
  localparam logic SLOT_FREE = 1'b0;
  localparam logic SLOT_BUSY = 1'b1;

  typedef enum logic [1:0] {
    OP_CLAIM_WRITE  = 2'd0,
    OP_COMMIT_WRITE = 2'd1,
    OP_CLAIM_READ   = 2'd2,
    OP_RELEASE_SLOT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RETRY = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    claim_pos;
    logic [SLOT_W-1:0]   claimed_slot;
    logic [OFFSET_W-1:0] payload_offset;
    logic [OCC_W-1:0]    occupancy;
  } out_t;

  // Decided result before the offset multiply
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } pend_t;

endpackage

// ===== hdl/srcm_ram.sv =====
module srcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/srcm_clear.sv =====
module srcm_clear #(
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  output logic              active,
  output logic [ADDR_W-1:0] addr
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  // Sweep every entry once after reset, then stop
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '0;
    end else if (active) begin
      if (addr == LAST) begin
        active <= 1'b0;
      end else begin
        addr <= addr + ADDR_W'(1);
      end
    end
  end

endmodule

// ===== hdl/srcm_result.sv =====
module srcm_result #(
  parameter int SEL_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  srcm_pkg::pend_t               pend,
  input  logic [SEL_W-1:0]              slot_full,
  input  logic [srcm_pkg::STRIDE_W-1:0] stride,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output srcm_pkg::out_t                out_item
);

  import srcm_pkg::*;

  localparam int PROD_W = SEL_W + STRIDE_W;

  logic [PROD_W-1:0]   product;
  logic [OFFSET_W-1:0] offset;

  // Slot times stride plus the state word, wrapped to the offset width
  assign product = PROD_W'(slot_full) * PROD_W'(stride);
  assign offset  = product[OFFSET_W-1:0] + STATE_WORD_BYTES;

  // Take a new item whenever the held one is gone or leaving
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load && free) begin
      out_item.status         <= pend.status;
      out_item.claim_pos      <= pend.position;
      out_item.claimed_slot   <= slot_full[SLOT_W-1:0];
      out_item.payload_offset <= offset;
      out_item.occupancy      <= pend.occupancy;
    end
  end

endmodule

// ===== hdl/slot_ring_claim_manager.sv =====
// Slot ring claim manager: write/read positions plus a per-slot busy map in a RAM.
// Path: an accepted item is registered in the decide stage (with the busy-map read), then in the output register.
// Flow: one item in flight; a new item is taken only once the last has left the decide stage,
// set by the busy-map read-modify-write (RAM read, then decide and write back).
// Reset (synchronous): positions zero, capacity_log2 8, stride 64; then a sweep clears
// all MAX_SLOTS busy-map entries (256 by default) with in_stall high; config taken.
module slot_ring_claim_manager #(
  parameter int MAX_SLOTS = srcm_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  srcm_pkg::in_t                   in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output srcm_pkg::out_t                  out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import srcm_pkg::*;

  localparam int TOP    = $clog2(MAX_SLOTS + 1) - 1;
  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SEL_W  = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
  localparam int LG_W   = 5;

  // Configuration
  logic [CAP_W-1:0]    cap_log2;
  logic [STRIDE_W-1:0] slot_stride;

  // Ring state
  logic [POS_W-1:0] write_pos;
  logic [POS_W-1:0] read_pos;
  logic [POS_W-1:0] write_pos_next;
  logic [POS_W-1:0] read_pos_next;

  // Mask
  logic [LG_W-1:0]  lg;
  logic [SEL_W:0]   mask_wide;
  logic [SEL_W-1:0] mask;

  // Accept side
  logic             in_accept;
  logic [SEL_W-1:0] acc_slot;
  logic             acc_release_ok;

  // Decide stage
  logic             s1_valid;
  op_t              s1_op;
  logic [POS_W-1:0] s1_pos;
  logic [SEL_W-1:0] s1_slot;
  logic             s1_release_ok;
  logic             s1_fire;

  logic             busy_rd;
  logic             upd_we;
  logic             upd_wdata;
  logic [POS_W-1:0] occ;
  logic [POS_W-1:0] occ_next;
  pend_t            pend;

  // Busy map ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;

  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;
  logic              res_free;

  // Configuration writes, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2    <= CAP_LOG2_RESET;
      slot_stride <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAPACITY_LOG2: cap_log2    <= cfg_data[CAP_W-1:0];
        CFG_SLOT_STRIDE:   slot_stride <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate capacity at the ring depth and build the slot mask
  assign lg        = ({1'b0, cap_log2} > LG_W'(TOP)) ? LG_W'(TOP) : {1'b0, cap_log2};
  assign mask_wide = ({{SEL_W{1'b0}}, 1'b1} << lg) - {{SEL_W{1'b0}}, 1'b1};
  assign mask      = mask_wide[SEL_W-1:0];

  // One item in flight; hold off during reset and the clearing sweep
  assign in_stall  = rst || clr_active || s1_valid;
  assign in_accept = in_valid && !in_stall;

  // Pick the slot this item addresses
  always_comb begin
    unique case (in_item.op)
      OP_CLAIM_WRITE:  acc_slot = write_pos[SEL_W-1:0] & mask;
      OP_COMMIT_WRITE: acc_slot = in_item.position[SEL_W-1:0] & mask;
      OP_CLAIM_READ:   acc_slot = read_pos[SEL_W-1:0] & mask;
      OP_RELEASE_SLOT: acc_slot = SEL_W'(in_item.slot);
      default:         acc_slot = '0;
    endcase
  end

  assign acc_release_ok = POS_W'(in_item.slot) < POS_W'(MAX_SLOTS);

  // Capture the item while the busy bit is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op         <= in_item.op;
      s1_pos        <= in_item.position;
      s1_slot       <= acc_slot;
      s1_release_ok <= acc_release_ok;
    end
  end

  assign s1_fire = s1_valid && res_free;
  assign occ     = write_pos - read_pos;

  // Decide status, pointer moves and the busy-map update
  always_comb begin
    write_pos_next = write_pos;
    read_pos_next  = read_pos;
    upd_we         = 1'b0;
    upd_wdata      = SLOT_FREE;
    pend.status    = ST_OK;
    pend.position  = '0;
    unique case (s1_op)
      OP_CLAIM_WRITE: begin
        pend.position = write_pos;
        if (busy_rd == SLOT_BUSY) begin
          pend.status = (occ > POS_W'(mask)) ? ST_FULL : ST_RETRY;
        end else begin
          upd_we    = 1'b1;
          upd_wdata = SLOT_BUSY;
        end
      end
      OP_COMMIT_WRITE: begin
        pend.position  = s1_pos;
        write_pos_next = s1_pos + POS_W'(1);
      end
      OP_CLAIM_READ: begin
        pend.position = read_pos;
        if (occ == '0 || occ[POS_W-1]) begin
          pend.status = ST_EMPTY;
        end else begin
          read_pos_next = read_pos + POS_W'(1);
        end
      end
      OP_RELEASE_SLOT: begin
        upd_we    = s1_release_ok;
        upd_wdata = SLOT_FREE;
      end
      default: ;
    endcase
    occ_next       = write_pos_next - read_pos_next;
    pend.occupancy = occ_next[OCC_W-1:0];
  end

  // Advance the positions when the result is taken into the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      read_pos  <= '0;
    end else if (s1_fire) begin
      write_pos <= write_pos_next;
      read_pos  <= read_pos_next;
    end
  end

  // Busy-map write: the clearing sweep, else the decided update
  assign ram_we    = clr_active || (s1_fire && upd_we);
  assign ram_waddr = clr_active ? clr_addr : s1_slot[ADDR_W-1:0];
  assign ram_wdata = clr_active ? SLOT_FREE : upd_wdata;

  srcm_clear #(
    .DEPTH (MAX_SLOTS)
  ) u_clear (
    .clk    (clk),
    .rst    (rst),
    .active (clr_active),
    .addr   (clr_addr)
  );

  srcm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_busy_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (acc_slot[ADDR_W-1:0]),
    .rdata (busy_rd)
  );

  srcm_result #(
    .SEL_W (SEL_W)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid),
    .pend      (pend),
    .slot_full (s1_slot),
    .stride    (slot_stride),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/srcm_checker.sv =====
module srcm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input srcm_pkg::out_t out_item
);

`include "slot_ring_claim_manager_defines.svh"

  // A stalled result stays put
  `SRCM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // Only one item in flight: an accept stalls the next cycle
  `SRCM_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // A fresh result comes from an accept that passed through the decide stage and the output register
  `SRCM_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

  // The clearing sweep holds off items right after reset
  `SRCM_ASSERT_IMP(a_sweep_after_reset, $past(rst), in_stall)

endmodule

bind slot_ring_claim_manager srcm_checker u_srcm_checker (.*);
